>>> sv/rld_pkg.sv
package rld_pkg;

	// Width of the decoded position range; the limit is at most 2^POSITION_BITS - 1.
	localparam int unsigned POSITION_BITS = 32;

	localparam logic [31:0] CAPACITY_RESET = 32'd65536;
	localparam logic [31:0] POSITION_TOP   = 32'((64'd1 << POSITION_BITS) - 64'd1);

	localparam logic [7:0] TAG_LITERAL = 8'h00;
	localparam logic [7:0] TAG_RUN     = 8'h01;

	typedef enum logic [2:0] {
		PH_TAG     = 3'd0,
		PH_LEN_LO  = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_BODY    = 3'd3,
		PH_RUN_VAL = 3'd4,
		PH_CNT_LO  = 3'd5,
		PH_CNT_HI  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_TAG   = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_value;
		logic [15:0] repeat_count;
		logic [31:0] write_offset;
		logic        stream_end;
		logic [1:0]  status;
		logic [31:0] total_length;
	} out_item_t;

	// Per-item handoff from the decoder to the result register
	typedef struct packed {
		logic      emit;
		out_item_t item;
	} dec_result_t;

endpackage

>>> sv/rld_if.sv
interface rld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface rld_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_value;
	logic [15:0] repeat_count;
	logic [31:0] write_offset;
	logic        stream_end;
	logic [1:0]  status;
	logic [31:0] total_length;

	modport source (output valid, output out_value, output repeat_count,
		output write_offset, output stream_end, output status, output total_length,
		input ready);
	modport sink   (input valid, input out_value, input repeat_count,
		input write_offset, input stream_end, input status, input total_length,
		output ready);
endinterface

>>> sv/rld_in_stage.sv
module rld_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	rld_in_if.sink            stream,
	input  logic              advance,
	output logic              valid_s1,
	output rld_pkg::in_item_t item_s1
);
	import rld_pkg::*;

	logic load;

	assign stream.ready = !valid_s1 || advance;
	assign load         = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.in_byte <= stream.in_byte;
			item_s1.in_last <= stream.in_last;
		end
	end

endmodule

>>> sv/rld_decode.sv
module rld_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [31:0]          cfg_wr_data,
	input  logic                 fire,
	input  rld_pkg::in_item_t    item,
	output rld_pkg::dec_result_t res
);
	import rld_pkg::*;

	logic [31:0] capacity_q;
	phase_t      phase_q, phase_d;
	logic [7:0]  length_low_q, length_low_d;
	logic [15:0] remaining_q, remaining_d;
	logic [7:0]  run_value_q, run_value_d;
	logic [31:0] position_q, position_d;
	status_t     error_q, error_d;

	logic [31:0] limit;
	logic [15:0] count;
	logic        overflow;
	logic        wrote;
	logic [7:0]  val;
	logic [15:0] rep;

	assign limit    = (capacity_q < POSITION_TOP) ? capacity_q : POSITION_TOP;
	assign count    = {item.in_byte, length_low_q};
	assign overflow = ({1'b0, position_q} + {17'd0, count}) > {1'b0, limit};

	always_comb begin
		phase_d      = phase_q;
		length_low_d = length_low_q;
		remaining_d  = remaining_q;
		run_value_d  = run_value_q;
		position_d   = position_q;
		error_d      = error_q;
		wrote        = 1'b0;
		val          = '0;
		rep          = '0;

		if (error_q == ST_OK) begin
			unique case (phase_q)
				PH_LEN_LO, PH_CNT_LO: begin
					length_low_d = item.in_byte;
					phase_d      = (phase_q == PH_LEN_LO) ? PH_LEN_HI : PH_CNT_HI;
				end
				PH_LEN_HI: begin
					if (overflow) begin
						error_d = ST_OVERFLOW;
					end else if (count == '0) begin
						phase_d = PH_TAG;
					end else begin
						remaining_d = count;
						phase_d     = PH_BODY;
					end
				end
				PH_BODY: begin
					wrote       = 1'b1;
					val         = item.in_byte;
					rep         = 16'd1;
					position_d  = position_q + 32'd1;
					remaining_d = remaining_q - 16'd1;
					if (remaining_d == '0) begin
						phase_d = PH_TAG;
					end
				end
				PH_RUN_VAL: begin
					run_value_d = item.in_byte;
					phase_d     = PH_CNT_LO;
				end
				PH_CNT_HI: begin
					if (overflow) begin
						error_d = ST_OVERFLOW;
					end else begin
						wrote      = 1'b1;
						val        = run_value_q;
						rep        = count;
						position_d = position_q + {16'd0, count};
						phase_d    = PH_TAG;
					end
				end
				default: begin
					// tag byte; an unused phase code behaves the same
					if (item.in_byte == TAG_LITERAL) begin
						phase_d = PH_LEN_LO;
					end else if (item.in_byte == TAG_RUN) begin
						phase_d = PH_RUN_VAL;
					end else begin
						phase_d = PH_TAG;
						error_d = ST_BAD_TAG;
					end
				end
			endcase
		end

		if (item.in_last && error_d == ST_OK && phase_d != PH_TAG) begin
			error_d = ST_TRUNCATED;
		end

		res.emit              = item.in_last || wrote;
		res.item.out_value    = val;
		res.item.repeat_count = rep;
		res.item.write_offset = position_q;
		res.item.stream_end   = item.in_last;
		res.item.status       = item.in_last ? error_d : ST_OK;
		res.item.total_length = (item.in_last && error_d == ST_OK) ? position_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TAG;
			length_low_q <= '0;
			remaining_q  <= '0;
			run_value_q  <= '0;
			position_q   <= '0;
			error_q      <= ST_OK;
		end else if (fire) begin
			if (item.in_last) begin
				// stream done: start fresh
				phase_q      <= PH_TAG;
				length_low_q <= '0;
				remaining_q  <= '0;
				run_value_q  <= '0;
				position_q   <= '0;
				error_q      <= ST_OK;
			end else begin
				phase_q      <= phase_d;
				length_low_q <= length_low_d;
				remaining_q  <= remaining_d;
				run_value_q  <= run_value_d;
				position_q   <= position_d;
				error_q      <= error_d;
			end
		end
	end

endmodule

>>> sv/rld_out_stage.sv
module rld_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	rld_out_if.source            result,
	input  logic                 valid_s1,
	input  rld_pkg::dec_result_t res,
	output logic                 advance
);
	import rld_pkg::*;

	logic      out_valid_q;
	out_item_t out_item_q;
	logic      load;

	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign load    = advance && res.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= res.item;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_value    = out_item_q.out_value;
	assign result.repeat_count = out_item_q.repeat_count;
	assign result.write_offset = out_item_q.write_offset;
	assign result.stream_end   = out_item_q.stream_end;
	assign result.status       = out_item_q.status;
	assign result.total_length = out_item_q.total_length;

endmodule

>>> sv/rle_literal_run_decoder_core.sv
// A compressed byte that transfers lands in the input register; when it advances,
// the decode state updates and the result register loads any result it yields.
// Throughput: one compressed byte per cycle unless a result waiting in the result
// register is not taken, which stalls the input register.
// Reset (arst_n low): stream state cleared, capacity back to 65536, both
// registers emptied.
module rle_literal_run_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	rld_in_if.sink      stream,
	rld_out_if.source   result
);
	import rld_pkg::*;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        advance;
	dec_result_t res;

	rld_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rld_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (advance),
		.item        (item_s1),
		.res         (res)
	);

	rld_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.valid_s1 (valid_s1),
		.res      (res),
		.advance  (advance)
	);

	// input side only backs up when a byte is held and cannot move on
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> valid_s1 && result.valid && !result.ready)
		else $error("input stalled without a blocked result");

	// a failed stream never reports a length
	a_error_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != ST_OK |-> result.total_length == '0)
		else $error("total_length set on an error status");

	// mid-stream results carry no final status
	a_mid_stream_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.stream_end |->
			result.status == ST_OK && result.total_length == '0)
		else $error("status or length on a non-final result");

	// a byte in the input register advances whenever the result register is empty
	a_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !result.valid |-> advance)
		else $error("held byte did not advance with the result register free");

endmodule

>>> tb/rle_literal_run_decoder_core_tb.sv
`timescale 1ns / 1ps

module rle_literal_run_decoder_core_tb;
	import rld_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_GAP    = 4;
	localparam int PHASE_ITEMS  = 340;
	localparam int PRINT_LIMIT  = 40;

	typedef logic [7:0] byte_q_t[$];

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	rld_in_if  stream_if ();
	rld_out_if result_if ();

	rle_literal_run_decoder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stream      (stream_if),
		.result      (result_if)
	);

	// decoder state as predicted
	phase_t      m_phase;
	status_t     m_err;
	logic [7:0]  m_len_lo;
	logic [15:0] m_lit_rem;
	logic [7:0]  m_run_val;
	logic [31:0] m_pos;
	logic [31:0] m_cap;

	out_item_t pending_results[$];

	int  mismatches;
	int  items_sent;
	int  cycle_count;
	int  stall_left;
	bit  hold_req;
	bit  src_idle_on;
	bit  sink_idle_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic clear_stream();
		m_phase   = PH_TAG;
		m_err     = ST_OK;
		m_len_lo  = '0;
		m_lit_rem = '0;
		m_run_val = '0;
		m_pos     = '0;
	endtask

	// Advance the decode state by one compressed byte, queue the result it yields.
	task automatic decode_byte(input logic [7:0] b, input logic last);
		out_item_t   r;
		logic        wrote;
		logic [15:0] n;
		logic [32:0] lim;
		r = '0;
		wrote = 1'b0;
		r.write_offset = m_pos;
		lim = (m_cap < POSITION_TOP) ? {1'b0, m_cap} : {1'b0, POSITION_TOP};
		if (m_err == ST_OK) begin
			case (m_phase)
				PH_TAG: begin
					if (b == TAG_LITERAL)
						m_phase = PH_LEN_LO;
					else if (b == TAG_RUN)
						m_phase = PH_RUN_VAL;
					else
						m_err = ST_BAD_TAG;
				end
				PH_LEN_LO: begin
					m_len_lo = b;
					m_phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					n = {b, m_len_lo};
					if ({1'b0, m_pos} + 33'(n) > lim)
						m_err = ST_OVERFLOW;
					else if (n == 16'd0)
						m_phase = PH_TAG;
					else begin
						m_lit_rem = n;
						m_phase = PH_BODY;
					end
				end
				PH_BODY: begin
					wrote = 1'b1;
					r.out_value = b;
					r.repeat_count = 16'd1;
					m_pos = m_pos + 32'd1;
					m_lit_rem = m_lit_rem - 16'd1;
					if (m_lit_rem == 16'd0)
						m_phase = PH_TAG;
				end
				PH_RUN_VAL: begin
					m_run_val = b;
					m_phase = PH_CNT_LO;
				end
				PH_CNT_LO: begin
					m_len_lo = b;
					m_phase = PH_CNT_HI;
				end
				PH_CNT_HI: begin
					n = {b, m_len_lo};
					if ({1'b0, m_pos} + 33'(n) > lim)
						m_err = ST_OVERFLOW;
					else begin
						wrote = 1'b1;
						r.out_value = m_run_val;
						r.repeat_count = n;
						m_pos = m_pos + 32'(n);
						m_phase = PH_TAG;
					end
				end
				default: m_phase = PH_TAG;
			endcase
		end
		if (last) begin
			if (m_err == ST_OK && m_phase != PH_TAG)
				m_err = ST_TRUNCATED;
			r.stream_end = 1'b1;
			r.status = m_err;
			r.total_length = (m_err == ST_OK) ? m_pos : 32'd0;
			pending_results.push_back(r);
			clear_stream();
		end else if (wrote) begin
			pending_results.push_back(r);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && stream_if.valid && stream_if.ready)
			decode_byte(stream_if.in_byte, stream_if.in_last);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", {24'd0, result_if.out_value}, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (result_if.out_value !== want.out_value)
					report_mismatch("out_value", 32'(result_if.out_value), 32'(want.out_value));
				if (result_if.repeat_count !== want.repeat_count)
					report_mismatch("repeat_count", 32'(result_if.repeat_count),
						32'(want.repeat_count));
				if (result_if.write_offset !== want.write_offset)
					report_mismatch("write_offset", result_if.write_offset, want.write_offset);
				if (result_if.stream_end !== want.stream_end)
					report_mismatch("stream_end", 32'(result_if.stream_end), 32'(want.stream_end));
				if (result_if.status !== want.status)
					report_mismatch("status", 32'(result_if.status), 32'(want.status));
				if (result_if.total_length !== want.total_length)
					report_mismatch("total_length", result_if.total_length, want.total_length);
			end
		end
	end

	// result sink: random stalls plus one long hold-off on request
	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				result_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				result_if.ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 13);
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			stream_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		stream_if.valid   <= 1'b1;
		stream_if.in_byte <= b;
		stream_if.in_last <= last;
		do @(posedge clk); while (!stream_if.ready);
		items_sent++;
	endtask

	task automatic send_stream(input byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	// Quiet the input and let every outstanding result come back.
	task automatic drain();
		stream_if.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [31:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		m_cap = v;
	endtask

	function automatic byte_q_t random_stream();
		byte_q_t     q;
		logic [15:0] n;
		int          ncmd;
		int          keep;
		// pure noise now and then
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) q.push_back(8'($urandom));
			return q;
		end
		ncmd = $urandom_range(1, 6);
		for (int i = 0; i < ncmd; i++) begin
			if ($urandom_range(0, 1) == 1) begin
				if ($urandom_range(0, 19) == 0) begin
					// huge literal: overflow at the header or cut short in the body
					n = 16'($urandom);
					q.push_back(TAG_LITERAL);
					q.push_back(n[7:0]);
					q.push_back(n[15:8]);
					repeat ($urandom_range(0, 5)) q.push_back(8'($urandom));
					return q;
				end
				n = 16'($urandom_range(0, 6));
				q.push_back(TAG_LITERAL);
				q.push_back(n[7:0]);
				q.push_back(n[15:8]);
				repeat (int'(n)) q.push_back(8'($urandom));
			end else begin
				n = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
				q.push_back(TAG_RUN);
				q.push_back(8'($urandom));
				q.push_back(n[7:0]);
				q.push_back(n[15:8]);
			end
		end
		case ($urandom_range(0, 9))
			0: begin
				q.push_back(8'($urandom_range(2, 255)));
				repeat ($urandom_range(0, 4)) q.push_back(8'($urandom));
			end
			1: begin
				keep = $urandom_range(1, q.size() - 1);
				while (q.size() > keep) void'(q.pop_back());
			end
			default: ;
		endcase
		return q;
	endfunction

	task automatic test_literals();
		send_stream('{TAG_LITERAL, 8'h02, 8'h00, 8'h00, 8'hFF});
		// zero-length literal closing the stream: nothing written
		send_stream('{TAG_LITERAL, 8'h00, 8'h00});
	endtask

	task automatic test_runs();
		send_stream('{TAG_RUN, 8'hFF, 8'h00, 8'h00, TAG_RUN, 8'h5A, 8'h03, 8'h00});
	endtask

	task automatic test_errors();
		send_stream('{8'h80, TAG_RUN, 8'h00});
		// body cut short with last on a body byte
		send_stream('{TAG_LITERAL, 8'h03, 8'h00, 8'h11});
	endtask

	task automatic test_backpressure();
		byte_q_t q;
		q = '{TAG_LITERAL, 8'd30, 8'h00};
		repeat (30) q.push_back(8'($urandom));
		hold_req = 1'b1;
		send_stream(q);
	endtask

	task automatic test_capacity();
		write_capacity(32'd1);
		send_stream('{TAG_RUN, 8'h22, 8'h02, 8'h00});
		// overflow wins over truncation
		send_stream('{TAG_LITERAL, 8'hFF, 8'hFF});
		send_stream('{TAG_LITERAL, 8'h01, 8'h00, 8'h7E});
		write_capacity(32'hFFFF_FFFF);
		send_stream('{TAG_RUN, 8'hC3, 8'hFF, 8'hFF});
	endtask

	task automatic test_random_streams();
		logic [31:0] caps[6];
		int          start;
		caps[0] = 32'hFFFF_FFFF;
		caps[1] = 32'($urandom_range(100, 3000));
		caps[2] = 32'd1;
		caps[3] = CAPACITY_RESET;
		caps[4] = 32'($urandom_range(1, 100));
		caps[5] = 32'd70000;
		foreach (caps[p]) begin
			write_capacity(caps[p]);
			if (p == 5) begin
				src_idle_on = 1'b0;
				sink_idle_on = 1'b0;
			end
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS)
				send_stream(random_stream());
		end
	endtask

	initial begin
		arst_n              <= 1'b0;
		cfg_wr_en           <= 1'b0;
		cfg_wr_data         <= '0;
		stream_if.valid     <= 1'b0;
		stream_if.in_byte   <= '0;
		stream_if.in_last   <= 1'b0;
		mismatches   = 0;
		items_sent   = 0;
		stall_left   = 0;
		hold_req     = 1'b0;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		m_cap = CAPACITY_RESET;
		clear_stream();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_literals();
		test_runs();
		test_errors();
		test_backpressure();
		test_capacity();
		test_random_streams();
		drain();

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
